/* rtl/breath_pressure_detector_assert.svh */
// Assertion macros for the breath pressure detector checker.
`ifndef BREATH_PRESSURE_DETECTOR_ASSERT_SVH
`define BREATH_PRESSURE_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BPD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("breath pressure detector: implication failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BPD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("breath pressure detector: next-cycle implication failed");

`endif

/* rtl/bpd_pkg.sv */
// Package of constants and types for the breath pressure detector.
`timescale 1ns / 1ps

package bpd_pkg;

   // Block configuration
   localparam int WINDOW      = 5;
   localparam int CAL_SAMPLES = 50;

   // Field widths
   localparam int ADC_W    = 12;
   localparam int P_W      = 18;
   localparam int GAIN_W   = 16;
   localparam int GAS_MV_W = 12;
   localparam int FRAC_W   = 6;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOW_THRESHOLD = 1'b0,
      CSR_PRESSURE_GAIN  = 1'b1
   } csr_index_type;

   localparam logic [P_W-1:0]    THRESHOLD_RESET = 18'd128;
   localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd14855;

   // Arithmetic constants
   localparam logic [P_W-1:0] P_MAX       = 18'd262143;
   localparam int             GAS_MV_FULL = 3300;
   localparam int             ADC_FULL    = 4095;
   localparam int             GAS_RND     = 2047;

   // Serial multiplier: 18-bit multiplicand, 16-bit multiplier, one bit a cycle
   localparam int MUL_A_W   = 18;
   localparam int MUL_B_W   = 16;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_STEPS = MUL_B_W;
   localparam int SCALE_SH  = 14;

   // Serial restoring divider: 24-bit dividend, 12-bit divisor
   localparam int DIV_N_W   = 24;
   localparam int DIV_D_W   = 12;
   localparam int DIV_STEPS = DIV_N_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Window bookkeeping
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = P_W + CNT_W;
   localparam int CAL_CNT_W = $clog2(CAL_SAMPLES + 1);

   // Result word layout, lowest bit first
   localparam int RSP_BLOW_LSB = 0;
   localparam int RSP_AVG_LSB  = 1;
   localparam int RSP_GAS_LSB  = RSP_AVG_LSB + P_W;
   localparam int RSP_USED_W   = RSP_GAS_LSB + GAS_MV_W;

endpackage

/* rtl/breath_pressure_detector.sv */
// Top level of the breath pressure detector: calibration, scaling, averaging, threshold.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------------
//  req      | in        | req_tvalid/req_tready  | tdata: pressure_raw, gas_raw
//  rsp      | out       | rsp_tvalid/rsp_tready  | tdata: blowing, pressure_avg, gas_mv
//  csr      | in        | csr_we                 | csr_index, csr_wdata (write only)
//
// One transaction at a time; req_tready is high only while the sequencer is idle.
// Calibration transactions only accumulate; the last one also runs a serial divide of the baseline.
// Later transactions multiply, sum the filled window entries and divide; a blowing report
// adds a gas multiply and divide; the multiplier runs 16 steps, the divider 24.
// Reset is synchronous; a finished result waits in the output register, which frees the
// sequencer, and it stalls only if a second result is ready before the first is taken.
`timescale 1ns / 1ps

module breath_pressure_detector (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: pressure_raw [11:0], gas_raw [23:12]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bpd_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tdata: blowing [0], pressure_avg [18:1], gas_millivolts [30:19], zero [31]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bpd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [bpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_BASE_DIV,
      S_BASE_SET,
      S_MUL_P,
      S_SCALE,
      S_SUM,
      S_DIV_AVG,
      S_AVG_CHK,
      S_MUL_G,
      S_GAS_RND,
      S_DIV_G,
      S_GAS_SET,
      S_DONE
   } state_type;

   // Control state
   state_type                              state_ff, state_in;
   logic [bpd_pkg::STEP_W-1:0]             step_ff, step_in;
   logic [bpd_pkg::CAL_CNT_W-1:0]          cal_cnt_ff, cal_cnt_in;
   logic [bpd_pkg::P_W-1:0]                cal_sum_ff, cal_sum_in;
   logic [bpd_pkg::P_W-1:0]                baseline_ff, baseline_in;
   logic [bpd_pkg::P_W-1:0]                thr_ff, thr_in;
   logic [bpd_pkg::GAIN_W-1:0]             gain_ff, gain_in;
   logic [bpd_pkg::SLOT_W-1:0]             slot_ff, slot_in;
   logic                                   full_ff, full_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [bpd_pkg::RSP_DATA_W-1:0]         rsp_data_ff, rsp_data_in;

   // Datapath registers
   logic [bpd_pkg::ADC_W-1:0]              gas_raw_ff, gas_raw_in;
   logic [bpd_pkg::MUL_A_W-1:0]            mcand_ff, mcand_in;
   logic [bpd_pkg::MUL_P_W-1:0]            prod_ff, prod_in;
   logic [bpd_pkg::DIV_D_W-1:0]            rem_ff, rem_in;
   logic [bpd_pkg::DIV_N_W-1:0]            quo_ff, quo_in;
   logic [bpd_pkg::DIV_D_W-1:0]            divisor_ff, divisor_in;
   logic [bpd_pkg::P_W-1:0]                win_ff [bpd_pkg::WINDOW];
   logic                                   win_we;
   logic [bpd_pkg::P_W-1:0]                win_wdata;
   logic [bpd_pkg::CNT_W-1:0]              count_ff, count_in;
   logic [bpd_pkg::CNT_W-1:0]              idx_ff, idx_in;
   logic [bpd_pkg::SUM_W-1:0]              sum_ff, sum_in;
   logic                                   blow_ff, blow_in;
   logic [bpd_pkg::P_W-1:0]                avg_ff, avg_in;
   logic [bpd_pkg::GAS_MV_W-1:0]           gas_mv_ff, gas_mv_in;

   // Combinational helpers
   logic                                   req_fire;
   logic [bpd_pkg::ADC_W-1:0]              p_raw;
   logic [bpd_pkg::P_W-1:0]                sample;
   logic [bpd_pkg::P_W-1:0]                delta;
   logic [bpd_pkg::P_W-1:0]                cal_sum_nx;
   logic [bpd_pkg::MUL_A_W:0]              mul_add;
   logic [bpd_pkg::MUL_P_W-1:0]            mul_next;
   logic [bpd_pkg::DIV_D_W:0]              rem_sh;
   logic [bpd_pkg::DIV_D_W+1:0]            div_diff;
   logic                                   div_ge;
   logic [bpd_pkg::MUL_P_W-bpd_pkg::SCALE_SH:0] scaled_rnd;
   logic [bpd_pkg::P_W-1:0]                scaled;
   logic [bpd_pkg::CNT_W-1:0]              slot_inc;
   logic                                   slot_wrap;
   logic [bpd_pkg::CNT_W-1:0]              count_new;
   logic [bpd_pkg::SUM_W-1:0]              sum_nx;
   logic [bpd_pkg::P_W-1:0]                avg_q;
   logic                                   mul_last;
   logic                                   div_last;
   logic                                   rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign p_raw = req_tdata[bpd_pkg::ADC_W-1:0];

   // Baseline subtraction with clamp at zero, both in Q12.6 counts
   assign sample     = {p_raw, {bpd_pkg::FRAC_W{1'b0}}};
   assign delta      = (sample > baseline_ff) ? (sample - baseline_ff) : '0;
   assign cal_sum_nx = cal_sum_ff + bpd_pkg::P_W'(p_raw);

   // Shift-add multiplier step: add multiplicand into the top half, shift right
   assign mul_add  = {1'b0, prod_ff[bpd_pkg::MUL_P_W-1:bpd_pkg::MUL_B_W]}
                   + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign mul_next = {mul_add, prod_ff[bpd_pkg::MUL_B_W-1:1]};

   // Restoring divider step: one quotient bit a cycle
   assign rem_sh   = {rem_ff, quo_ff[bpd_pkg::DIV_N_W-1]};
   assign div_diff = {1'b0, rem_sh} - {2'b00, divisor_ff};
   assign div_ge   = !div_diff[bpd_pkg::DIV_D_W+1];

   // Round the Q.22 product to 1/256 mmHg and saturate
   assign scaled_rnd = {1'b0, prod_ff[bpd_pkg::MUL_P_W-1:bpd_pkg::SCALE_SH]}
                     + (bpd_pkg::MUL_P_W - bpd_pkg::SCALE_SH + 1)'(prod_ff[bpd_pkg::SCALE_SH-1]);
   assign scaled     = (scaled_rnd > (bpd_pkg::MUL_P_W - bpd_pkg::SCALE_SH + 1)'(bpd_pkg::P_MAX))
                     ? bpd_pkg::P_MAX : scaled_rnd[bpd_pkg::P_W-1:0];

   // Window slot and fill count after this write
   assign slot_inc  = bpd_pkg::CNT_W'(slot_ff) + bpd_pkg::CNT_W'(1);
   assign slot_wrap = (slot_inc == bpd_pkg::CNT_W'(bpd_pkg::WINDOW));
   assign count_new = (slot_wrap || full_ff) ? bpd_pkg::CNT_W'(bpd_pkg::WINDOW) : slot_inc;

   assign sum_nx   = sum_ff + bpd_pkg::SUM_W'(win_ff[idx_ff[bpd_pkg::SLOT_W-1:0]]);
   assign avg_q    = quo_ff[bpd_pkg::P_W-1:0];
   assign mul_last = (step_ff == bpd_pkg::STEP_W'(bpd_pkg::MUL_STEPS - 1));
   assign div_last = (step_ff == bpd_pkg::STEP_W'(bpd_pkg::DIV_STEPS - 1));

   // Sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff + bpd_pkg::STEP_W'(1);
      cal_cnt_in   = cal_cnt_ff;
      cal_sum_in   = cal_sum_ff;
      baseline_in  = baseline_ff;
      thr_in       = thr_ff;
      gain_in      = gain_ff;
      slot_in      = slot_ff;
      full_in      = full_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      gas_raw_in   = gas_raw_ff;
      mcand_in     = mcand_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      win_we       = 1'b0;
      win_wdata    = scaled;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      blow_in      = blow_ff;
      avg_in       = avg_ff;
      gas_mv_in    = gas_mv_ff;

      // Register writes; unknown indexes cannot occur at this index width
      if (csr_we) begin
         unique case (bpd_pkg::csr_index_type'(csr_index))
            bpd_pkg::CSR_BLOW_THRESHOLD: thr_in  = csr_wdata[bpd_pkg::P_W-1:0];
            bpd_pkg::CSR_PRESSURE_GAIN:  gain_in = csr_wdata[bpd_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_fire) begin
               gas_raw_in = req_tdata[bpd_pkg::REQ_DATA_W-1:bpd_pkg::ADC_W];
               if (cal_cnt_ff < bpd_pkg::CAL_CNT_W'(bpd_pkg::CAL_SAMPLES)) begin
                  cal_sum_in = cal_sum_nx;
                  cal_cnt_in = cal_cnt_ff + bpd_pkg::CAL_CNT_W'(1);
                  if (cal_cnt_in == bpd_pkg::CAL_CNT_W'(bpd_pkg::CAL_SAMPLES)) begin
                     quo_in     = bpd_pkg::DIV_N_W'({cal_sum_nx, {bpd_pkg::FRAC_W{1'b0}}})
                                + bpd_pkg::DIV_N_W'(bpd_pkg::CAL_SAMPLES / 2);
                     rem_in     = '0;
                     divisor_in = bpd_pkg::DIV_D_W'(bpd_pkg::CAL_SAMPLES);
                     state_in   = S_BASE_DIV;
                  end
               end else begin
                  prod_in  = bpd_pkg::MUL_P_W'(gain_ff);
                  mcand_in = delta;
                  state_in = S_MUL_P;
               end
            end
         end
         S_BASE_DIV: begin
            rem_in = div_ge ? div_diff[bpd_pkg::DIV_D_W-1:0] : rem_sh[bpd_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[bpd_pkg::DIV_N_W-2:0], div_ge};
            if (div_last) begin
               state_in = S_BASE_SET;
            end
         end
         S_BASE_SET: begin
            baseline_in = (quo_ff > bpd_pkg::DIV_N_W'(bpd_pkg::P_MAX))
                        ? bpd_pkg::P_MAX : quo_ff[bpd_pkg::P_W-1:0];
            state_in    = S_IDLE;
         end
         S_MUL_P: begin
            prod_in = mul_next;
            if (mul_last) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            // Store the scaled sample and start the sum at the rounding term
            win_we   = 1'b1;
            slot_in  = slot_wrap ? '0 : slot_inc[bpd_pkg::SLOT_W-1:0];
            full_in  = full_ff || slot_wrap;
            count_in = count_new;
            idx_in   = '0;
            sum_in   = bpd_pkg::SUM_W'(count_new >> 1);
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in = sum_nx;
            idx_in = idx_ff + bpd_pkg::CNT_W'(1);
            if (idx_in == count_ff) begin
               quo_in     = bpd_pkg::DIV_N_W'(sum_nx);
               rem_in     = '0;
               divisor_in = bpd_pkg::DIV_D_W'(count_ff);
               step_in    = '0;
               state_in   = S_DIV_AVG;
            end
         end
         S_DIV_AVG: begin
            rem_in = div_ge ? div_diff[bpd_pkg::DIV_D_W-1:0] : rem_sh[bpd_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[bpd_pkg::DIV_N_W-2:0], div_ge};
            if (div_last) begin
               state_in = S_AVG_CHK;
            end
         end
         S_AVG_CHK: begin
            step_in = '0;
            if (avg_q > thr_ff) begin
               blow_in  = 1'b1;
               avg_in   = avg_q;
               prod_in  = bpd_pkg::MUL_P_W'(gas_raw_ff);
               mcand_in = bpd_pkg::MUL_A_W'(bpd_pkg::GAS_MV_FULL);
               state_in = S_MUL_G;
            end else begin
               blow_in   = 1'b0;
               avg_in    = '0;
               gas_mv_in = '0;
               state_in  = S_DONE;
            end
         end
         S_MUL_G: begin
            prod_in = mul_next;
            if (mul_last) begin
               state_in = S_GAS_RND;
            end
         end
         S_GAS_RND: begin
            quo_in     = prod_ff[bpd_pkg::DIV_N_W-1:0] + bpd_pkg::DIV_N_W'(bpd_pkg::GAS_RND);
            rem_in     = '0;
            divisor_in = bpd_pkg::DIV_D_W'(bpd_pkg::ADC_FULL);
            step_in    = '0;
            state_in   = S_DIV_G;
         end
         S_DIV_G: begin
            rem_in = div_ge ? div_diff[bpd_pkg::DIV_D_W-1:0] : rem_sh[bpd_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[bpd_pkg::DIV_N_W-2:0], div_ge};
            if (div_last) begin
               state_in = S_GAS_SET;
            end
         end
         S_GAS_SET: begin
            gas_mv_in = quo_ff[bpd_pkg::GAS_MV_W-1:0];
            state_in  = S_DONE;
         end
         S_DONE: begin
            // Hand over to the output register once it is free
            if (rsp_free) begin
               rsp_data_in  = bpd_pkg::RSP_DATA_W'({gas_mv_ff, avg_ff, blow_ff});
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State, control counters and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cal_cnt_ff   <= '0;
         cal_sum_ff   <= '0;
         baseline_ff  <= '0;
         thr_ff       <= bpd_pkg::THRESHOLD_RESET;
         gain_ff      <= bpd_pkg::GAIN_RESET;
         slot_ff      <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cal_cnt_ff   <= cal_cnt_in;
         cal_sum_ff   <= cal_sum_in;
         baseline_ff  <= baseline_in;
         thr_ff       <= thr_in;
         gain_ff      <= gain_in;
         slot_ff      <= slot_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      gas_raw_ff <= gas_raw_in;
      mcand_ff   <= mcand_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      count_ff   <= count_in;
      idx_ff     <= idx_in;
      sum_ff     <= sum_in;
      blow_ff    <= blow_in;
      avg_ff     <= avg_in;
      gas_mv_ff  <= gas_mv_in;
      if (win_we) begin
         win_ff[slot_ff] <= win_wdata;
      end
   end

endmodule

/* rtl/bpd_checker.sv */
// Port-level checker for the breath pressure detector, bound to the top level.
`timescale 1ns / 1ps
`include "breath_pressure_detector_assert.svh"

module bpd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bpd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic                          blow_bit;
   logic [bpd_pkg::P_W-1:0]       avg_field;
   logic [bpd_pkg::GAS_MV_W-1:0]  gas_field;

   assign blow_bit  = rsp_tdata[bpd_pkg::RSP_BLOW_LSB];
   assign avg_field = rsp_tdata[bpd_pkg::RSP_AVG_LSB +: bpd_pkg::P_W];
   assign gas_field = rsp_tdata[bpd_pkg::RSP_GAS_LSB +: bpd_pkg::GAS_MV_W];

   // A stalled result transaction keeps its payload
   `BPD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                   rsp_tvalid && $stable(rsp_tdata))

   // Idle report carries zero average and zero gas voltage
   `BPD_ASSERT_IMP(a_idle_zero, clock, reset, rsp_tvalid && !blow_bit,
                   (avg_field == '0) && (gas_field == '0))

   // Blowing means a nonzero average and a gas voltage within the supply range
   `BPD_ASSERT_IMP(a_blow_range, clock, reset, rsp_tvalid && blow_bit,
                   (avg_field != '0) && (gas_field <= bpd_pkg::GAS_MV_W'(bpd_pkg::GAS_MV_FULL)))

   // Padding above the packed fields stays zero
   `BPD_ASSERT_IMP(a_pad_zero, clock, reset, rsp_tvalid,
                   rsp_tdata[bpd_pkg::RSP_DATA_W-1:bpd_pkg::RSP_USED_W] == '0)

endmodule

bind breath_pressure_detector bpd_checker u_bpd_checker (.*);

/* bench/breath_pressure_detector_test.sv */
// Self-checking bench for the breath pressure detector: calibration, scaling, averaging.
`timescale 1ns / 1ps

module breath_pressure_detector_test;

   // settle time covers the longest transaction, a blowing report with a full window, plus the output register
   localparam int SETTLE_CYCLES = 150;

   typedef struct packed {
      logic [bpd_pkg::ADC_W-1:0] gas;
      logic [bpd_pkg::ADC_W-1:0] pressure;
   } sample_type;

   typedef struct {
      logic                         blowing;
      logic [bpd_pkg::P_W-1:0]      avg;
      logic [bpd_pkg::GAS_MV_W-1:0] gas_mv;
   } reading_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bpd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bpd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [bpd_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [bpd_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   sample_type  samples_pending[$];
   reading_type readings_due[$];
   logic        req_taken     = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          fault_count   = 0;

   // predictor state and its copy of the registers
   int unsigned                cal_seen    = 0;
   logic [bpd_pkg::P_W-1:0]    cal_total   = '0;
   logic [bpd_pkg::P_W-1:0]    baseline_q6 = '0;
   logic [bpd_pkg::P_W-1:0]    avg_slots [bpd_pkg::WINDOW];
   int unsigned                next_slot   = 0;
   bit                         slots_full  = 1'b0;
   logic [bpd_pkg::P_W-1:0]    thr_cfg     = bpd_pkg::THRESHOLD_RESET;
   logic [bpd_pkg::GAIN_W-1:0] gain_cfg    = bpd_pkg::GAIN_RESET;

   breath_pressure_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Expected reading for one sample; returns 0 while calibrating
   function automatic bit predict_reading(input sample_type s, output reading_type r);
      logic [bpd_pkg::P_W-1:0] sample_q6;
      longint unsigned         delta, prod, scaled, total, filled, mean, b;
      int                      i;
      r = '{1'b0, '0, '0};
      if (cal_seen < bpd_pkg::CAL_SAMPLES) begin
         cal_total = cal_total + s.pressure;
         cal_seen++;
         if (cal_seen == bpd_pkg::CAL_SAMPLES) begin
            b = ((64'(cal_total) << bpd_pkg::FRAC_W) + bpd_pkg::CAL_SAMPLES / 2)
              / bpd_pkg::CAL_SAMPLES;
            baseline_q6 = (b > bpd_pkg::P_MAX) ? bpd_pkg::P_MAX : b[bpd_pkg::P_W-1:0];
         end
         return 1'b0;
      end
      // baseline removal, clamp at zero, gain into 1/256 mmHg
      sample_q6 = {s.pressure, {bpd_pkg::FRAC_W{1'b0}}};
      delta = (sample_q6 > baseline_q6) ? 64'(sample_q6 - baseline_q6) : 64'd0;
      prod = delta * gain_cfg;
      scaled = (prod + (64'd1 << (bpd_pkg::SCALE_SH - 1))) >> bpd_pkg::SCALE_SH;
      if (scaled > bpd_pkg::P_MAX)
         scaled = bpd_pkg::P_MAX;
      // moving average over the entries filled so far
      avg_slots[next_slot] = scaled[bpd_pkg::P_W-1:0];
      next_slot++;
      if (next_slot == bpd_pkg::WINDOW) begin
         next_slot = 0;
         slots_full = 1'b1;
      end
      filled = slots_full ? bpd_pkg::WINDOW : next_slot;
      total = 0;
      for (i = 0; i < filled; i++)
         total += avg_slots[i];
      mean = (total + filled / 2) / filled;
      if (mean > thr_cfg) begin
         r.blowing = 1'b1;
         r.avg     = mean[bpd_pkg::P_W-1:0];
         r.gas_mv  = bpd_pkg::GAS_MV_W'((s.gas * bpd_pkg::GAS_MV_FULL + bpd_pkg::GAS_RND)
                                        / bpd_pkg::ADC_FULL);
      end
      return 1'b1;
   endfunction

   function automatic void note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("mismatch at %0t: %s", $time, msg);
   endfunction

   // Request driver: a new transaction once the previous one is taken
   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (samples_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= samples_pending.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: check results, then predict for accepted requests
   always @(posedge clock) begin : monitor
      reading_type seen, want;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.blowing = rsp_tdata[bpd_pkg::RSP_BLOW_LSB];
            seen.avg     = rsp_tdata[bpd_pkg::RSP_AVG_LSB +: bpd_pkg::P_W];
            seen.gas_mv  = rsp_tdata[bpd_pkg::RSP_GAS_LSB +: bpd_pkg::GAS_MV_W];
            if (readings_due.size() == 0) begin
               note_fault($sformatf("result %h with nothing expected", rsp_tdata));
            end else begin
               want = readings_due.pop_front();
               if (seen.blowing !== want.blowing)
                  note_fault($sformatf("blowing expected %0d got %0d",
                                       want.blowing, seen.blowing));
               if (seen.avg !== want.avg)
                  note_fault($sformatf("pressure_avg expected %0d got %0d",
                                       want.avg, seen.avg));
               if (seen.gas_mv !== want.gas_mv)
                  note_fault($sformatf("gas_millivolts expected %0d got %0d",
                                       want.gas_mv, seen.gas_mv));
               if (rsp_tdata[bpd_pkg::RSP_DATA_W-1:bpd_pkg::RSP_USED_W] !== '0)
                  note_fault($sformatf("padding bits not zero in %h", rsp_tdata));
            end
         end
         if (req_tvalid && req_tready && predict_reading(sample_type'(req_tdata), want))
            readings_due.push_back(want);
      end
   end

   // Wait until all transactions are through and the block has settled
   task automatic wait_quiet();
      do @(posedge clock);
      while (samples_pending.size() != 0 || req_tvalid || readings_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on consecutive cycles; block is idle here
   task automatic set_config(input logic [bpd_pkg::P_W-1:0]        thr,
                             input logic [bpd_pkg::CSR_DATA_W-1:0] gain_word);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= bpd_pkg::CSR_BLOW_THRESHOLD;
      csr_wdata <= thr;
      thr_cfg = thr;
      @(negedge clock);
      csr_index <= bpd_pkg::CSR_PRESSURE_GAIN;
      csr_wdata <= gain_word;
      gain_cfg = gain_word[bpd_pkg::GAIN_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(input int p, input int g);
      samples_pending.push_back('{gas: g[bpd_pkg::ADC_W-1:0], pressure: p[bpd_pkg::ADC_W-1:0]});
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 61; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 61; end
         default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
   endtask

   // Breaths: runs of high pressure, runs near the baseline, some noise
   task automatic breath_phase(input int n);
      int sent, run, base_counts, lo, hi, p, roll;
      bit exhale;
      sent = 0;
      base_counts = int'(baseline_q6 >> bpd_pkg::FRAC_W);
      lo = (base_counts > 48) ? base_counts - 48 : 0;
      hi = (base_counts + 48 > bpd_pkg::ADC_FULL) ? bpd_pkg::ADC_FULL : base_counts + 48;
      while (sent < n) begin
         exhale = $urandom_range(1);
         run = $urandom_range(12, 3);
         repeat (run) begin
            roll = $urandom_range(99);
            if (roll < 15)
               p = $urandom_range(bpd_pkg::ADC_FULL);
            else if (exhale)
               p = $urandom_range(bpd_pkg::ADC_FULL, base_counts);
            else
               p = $urandom_range(hi, lo);
            send(p, $urandom_range(bpd_pkg::ADC_FULL));
            sent++;
         end
      end
   endtask

   // Stimulus sequence
   initial begin : stimulus
      int base_counts, ph;
      logic [bpd_pkg::P_W-1:0] thr;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling(0);
      set_config(bpd_pkg::THRESHOLD_RESET, bpd_pkg::CSR_DATA_W'(bpd_pkg::GAIN_RESET));

      // calibration: extremes first, then a resting level
      send(0, 0);
      send(bpd_pkg::ADC_FULL, bpd_pkg::ADC_FULL);
      repeat (bpd_pkg::CAL_SAMPLES - 2)
         send($urandom_range(2400, 1700), $urandom_range(bpd_pkg::ADC_FULL));
      wait_quiet();
      base_counts = int'(baseline_q6 >> bpd_pkg::FRAC_W);

      // reset-value registers: clamp below baseline, full scale, window filling
      send(0, 0);
      send(bpd_pkg::ADC_FULL, bpd_pkg::ADC_FULL);
      send(bpd_pkg::ADC_FULL, 2048);
      send(base_counts, 1);
      send(base_counts + 1, bpd_pkg::ADC_FULL);
      send(2047, 2047);
      wait_quiet();

      // zero threshold, full gain with stray upper data bits: saturation, decay to zero
      set_config('0, {2'b11, 16'hFFFF});
      send(bpd_pkg::ADC_FULL, bpd_pkg::ADC_FULL);
      send(bpd_pkg::ADC_FULL, 0);
      repeat (bpd_pkg::WINDOW) send(0, bpd_pkg::ADC_FULL);
      wait_quiet();

      // threshold at its top: saturated average is not above it
      set_config(bpd_pkg::P_MAX, bpd_pkg::CSR_DATA_W'(16'hFFFF));
      repeat (bpd_pkg::WINDOW) send(bpd_pkg::ADC_FULL, 1234);
      wait_quiet();

      // one below the top: saturated average reports blowing
      set_config(bpd_pkg::P_MAX - 1, bpd_pkg::CSR_DATA_W'(16'hFFFF));
      send(bpd_pkg::ADC_FULL, 3000);
      wait_quiet();

      // zero gain
      set_config(bpd_pkg::THRESHOLD_RESET, '0);
      send(bpd_pkg::ADC_FULL, 100);
      wait_quiet();

      // random phases, each with its own registers and idling pattern
      for (ph = 0; ph < 8; ph++) begin
         thr = ($urandom_range(3) == 0) ? bpd_pkg::P_W'($urandom_range(bpd_pkg::P_MAX))
                                        : bpd_pkg::P_W'($urandom_range(40000));
         set_config(thr, {2'($urandom_range(3)), 16'($urandom_range(65535))});
         set_idling(ph % 4);
         breath_phase(175);
         wait_quiet();
      end

      if (readings_due.size() != 0)
         note_fault($sformatf("%0d results never arrived", readings_due.size()));
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      #10ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/bpd_pkg.sv
rtl/breath_pressure_detector.sv
rtl/bpd_checker.sv
bench/breath_pressure_detector_test.sv
